/* rtl/core/assert_macros.svh */
// Assertion macros shared by the RTL of the trigger readout buffer scheduler.
// Synthesis builds see empty bodies; no other file is needed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The property must hold at every clock edge outside reset.
`define TRBS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: assertion failed");

// The expression must never be true outside reset.
`define TRBS_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");

`else

`define TRBS_ASSERT(lbl, clk, rst_n, prop)
`define TRBS_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

/* rtl/core/trbs_pkg.sv */
// Package of the trigger readout buffer scheduler: sizes, timing constants,
// the slot type and the residue helpers. It depends on nothing else.
package trbs_pkg;

	localparam int BUF_DEPTH      = 64;
	localparam int TIME_BITS      = 48;
	localparam int READS_PER_TRIG = 6;

	localparam int PTR_W = $clog2(BUF_DEPTH);
	localparam int CNT_W = $clog2(BUF_DEPTH + 1);
	localparam int RD_W  = $clog2(READS_PER_TRIG + 1);

	localparam int CLK_NS       = 24;
	localparam int SYNC_NS      = 35 * 24;
	localparam int POP_AGE      = 840;
	localparam int READ_SPACING = 3360;

	localparam int DELAY_W  = 20;
	localparam int PHASE_W  = 10;
	localparam int OFFSET_W = 21;
	localparam int OCC_W    = 7;
	localparam int CLK_W    = $clog2(CLK_NS);

	localparam int IN_TDATA_W   = ((TIME_BITS + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = OFFSET_W + PHASE_W + OCC_W + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DELAY_W;
	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_DELAY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_PHASE    = 1'd1;

	// Residues mod 840 are taken seven bits per cycle, most significant digit first.
	localparam int DIG_W     = 7;
	localparam int RES_N     = (TIME_BITS + 1 + DIG_W - 1) / DIG_W;
	localparam int RES_W     = RES_N * DIG_W;
	localparam int RES_CNT_W = $clog2(RES_N);

	localparam int X_W       = PHASE_W + DIG_W;
	localparam int M840_K    = 2497;
	localparam int M840_S    = 21;
	localparam int M840_P_W  = X_W + 12;
	localparam int M24_K     = 171;
	localparam int M24_S     = 12;
	localparam int M24_P_W   = PHASE_W + 8;

	localparam logic signed [TIME_BITS:0] OFS_HI = (TIME_BITS + 1)'(2 ** (OFFSET_W - 1) - 1);
	localparam logic signed [TIME_BITS:0] OFS_LO = (TIME_BITS + 1)'(-(2 ** (OFFSET_W - 1)));

	typedef struct packed {
		logic [PHASE_W-1:0]   phase;
		logic [TIME_BITS-1:0] rtime;
	} slot_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(BUF_DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	// One digit step of (r * 128 + d) mod 840 with r below 840. The reciprocal
	// estimate is never low and at most one too high, so one correction suffices.
	function automatic logic [PHASE_W-1:0] mod840_step(input logic [PHASE_W-1:0] r,
	                                                   input logic [DIG_W-1:0] d);
		logic [X_W-1:0]      x;
		logic [M840_P_W-1:0] p;
		logic [M840_P_W-1:0] qm;
		logic [M840_P_W-1:0] rem;
		x   = {r, d};
		p   = M840_P_W'(x) * M840_P_W'(M840_K);
		qm  = (p >> M840_S) * M840_P_W'(SYNC_NS);
		if (qm > M840_P_W'(x)) begin
			rem = M840_P_W'(x) + M840_P_W'(SYNC_NS) - qm;
		end else begin
			rem = M840_P_W'(x) - qm;
		end
		return rem[PHASE_W-1:0];
	endfunction

	// x mod 24 for a ten-bit x, by the same estimate and correction.
	function automatic logic [CLK_W-1:0] mod24_small(input logic [PHASE_W-1:0] x);
		logic [M24_P_W-1:0] p;
		logic [M24_P_W-1:0] qm;
		logic [M24_P_W-1:0] rem;
		p  = M24_P_W'(x) * M24_P_W'(M24_K);
		qm = (p >> M24_S) * M24_P_W'(CLK_NS);
		if (qm > M24_P_W'(x)) begin
			rem = M24_P_W'(x) + M24_P_W'(CLK_NS) - qm;
		end else begin
			rem = M24_P_W'(x) - qm;
		end
		return rem[CLK_W-1:0];
	endfunction

endpackage

/* rtl/core/trigger_readout_buffer_scheduler.sv */
// A result follows each input transfer once stale slots are retired (one pop per cycle), the two
// serial mod-840 residues (7 digits each) are taken and the six slot writes are done through the
// one write port of the slot memory; no new item is accepted until the result is registered.
// Reset: arst_n clears pointers, count, last read time, registers and valid flags.
// The slot memory is not cleared; only the count_q entries from the head pointer on are ever used.
// Top level and only module; uses trbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module trigger_readout_buffer_scheduler
	import trbs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// event_time
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// head_offset, head_event_phase, occupancy, overflow, zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_we,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RES_EV,
		ST_MOD24,
		ST_ARR,
		ST_RES_ARR,
		ST_SYNC,
		ST_FIRST,
		ST_PUSH,
		ST_HEAD_RD,
		ST_HEAD_OUT
	} state_t;

	state_t state_q;

	logic [DELAY_W-1:0]   delay_q;
	logic [PHASE_W-1:0]   sphase_q;

	logic [TIME_BITS-1:0] ev_q;
	logic [TIME_BITS-1:0] arr_q;
	logic [TIME_BITS-1:0] sync_q;
	logic [TIME_BITS-1:0] last_q;
	logic [PHASE_W-1:0]   ev_ph_q;
	logic [PHASE_W-1:0]   res_q;
	logic [RES_W-1:0]     res_sh_q;
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic [CLK_W-1:0]     em24_q;
	logic [CLK_W-1:0]     cp24_q;
	logic [PTR_W-1:0]     head_q;
	logic [PTR_W-1:0]     tail_q;
	logic [CNT_W-1:0]     count_q;
	logic [RD_W-1:0]      push_cnt_q;
	logic                 drop_q;
	logic                 pop_busy_q;

	logic                 m_tvalid_q;
	logic [OFFSET_W-1:0]  out_ofs_q;
	logic [PHASE_W-1:0]   out_ph_q;
	logic [OCC_W-1:0]     out_occ_q;
	logic                 out_ovf_q;

	slot_t                mem [BUF_DEPTH];
	slot_t                rdata_q;
	logic [PTR_W-1:0]     raddr;
	logic                 mem_we;

	logic                 accept;
	logic                 pop_go;
	logic                 out_free;
	logic [DIG_W-1:0]     res_digit;
	logic [PHASE_W-1:0]   res_step;
	logic [CLK_W:0]       clk_sum;
	logic [CLK_W-1:0]     clk_rem;
	logic [CLK_W-1:0]     clk_adj;
	logic [TIME_BITS+1:0] arr_full;
	logic [TIME_BITS-1:0] arr_next;
	logic [TIME_BITS:0]   arr_ph;
	logic [PHASE_W-1:0]   sync_add;
	logic [TIME_BITS:0]   sync_full;
	logic [TIME_BITS-1:0] chained;
	logic [TIME_BITS-1:0] first;
	logic signed [TIME_BITS:0] diff;
	logic [OFFSET_W-1:0]  ofs_sat;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_TDATA_W'({out_ovf_q, out_occ_q, out_ph_q, out_ofs_q});
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= '0;
			sphase_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TRIGGER_DELAY: delay_q  <= cfg_data[DELAY_W-1:0];
				REG_SYNC_PHASE:    sphase_q <= cfg_data[PHASE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		pop_go = pop_busy_q && (count_q != '0) &&
		         (({1'b0, rdata_q.rtime} + (TIME_BITS + 1)'(POP_AGE)) < {1'b0, ev_q});
		raddr  = pop_go ? next_ptr(head_q) : head_q;
		mem_we = (state_q == ST_PUSH) && (count_q < CNT_W'(BUF_DEPTH));

		res_digit = res_sh_q[RES_W-1 -: DIG_W];
		res_step  = mod840_step(res_q, res_digit);

		clk_sum = {1'b0, em24_q} + {1'b0, cp24_q};
		if (clk_sum >= (CLK_W + 1)'(CLK_NS)) begin
			clk_rem = CLK_W'(clk_sum - (CLK_W + 1)'(CLK_NS));
		end else begin
			clk_rem = clk_sum[CLK_W-1:0];
		end
		clk_adj  = CLK_W'(CLK_NS) - clk_rem;
		arr_full = (TIME_BITS + 2)'(ev_q) + (TIME_BITS + 2)'(delay_q) +
		           (TIME_BITS + 2)'(clk_adj);
		arr_next = arr_full[TIME_BITS-1:0];
		arr_ph   = (TIME_BITS + 1)'(arr_next) + (TIME_BITS + 1)'(sphase_q);

		sync_add  = PHASE_W'(SYNC_NS) - res_q;
		sync_full = (TIME_BITS + 1)'(arr_q) + (TIME_BITS + 1)'(sync_add);

		chained = last_q + TIME_BITS'(READ_SPACING);
		if (count_q == '0) begin
			first = sync_q;
		end else begin
			first = (chained > sync_q) ? chained : sync_q;
		end

		diff = $signed({1'b0, rdata_q.rtime}) - $signed({1'b0, ev_q});
		if (diff > OFS_HI) begin
			ofs_sat = OFS_HI[OFFSET_W-1:0];
		end else if (diff < OFS_LO) begin
			ofs_sat = OFS_LO[OFFSET_W-1:0];
		end else begin
			ofs_sat = diff[OFFSET_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tail_q] <= '{phase: ev_ph_q, rtime: last_q};
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			last_q     <= '0;
			pop_busy_q <= 1'b0;
			drop_q     <= 1'b0;
			m_tvalid_q <= 1'b0;
			push_cnt_q <= '0;
			res_cnt_q  <= '0;
			ev_q       <= '0;
			arr_q      <= '0;
			sync_q     <= '0;
			ev_ph_q    <= '0;
			res_q      <= '0;
			res_sh_q   <= '0;
			em24_q     <= '0;
			cp24_q     <= '0;
			out_ofs_q  <= '0;
			out_ph_q   <= '0;
			out_occ_q  <= '0;
			out_ovf_q  <= 1'b0;
		end else begin
			if ((state_q == ST_HEAD_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			if (pop_go) begin
				head_q  <= next_ptr(head_q);
				count_q <= count_q - 1'b1;
			end else if (pop_busy_q) begin
				pop_busy_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						ev_q       <= s_tdata[TIME_BITS-1:0];
						res_sh_q   <= RES_W'(s_tdata[TIME_BITS-1:0]);
						res_q      <= '0;
						res_cnt_q  <= RES_CNT_W'(RES_N - 1);
						pop_busy_q <= 1'b1;
						drop_q     <= 1'b0;
						state_q    <= ST_RES_EV;
					end
				end
				ST_RES_EV: begin
					res_q    <= res_step;
					res_sh_q <= res_sh_q << DIG_W;
					if (res_cnt_q == '0) begin
						ev_ph_q <= res_step;
						state_q <= ST_MOD24;
					end else begin
						res_cnt_q <= res_cnt_q - 1'b1;
					end
				end
				ST_MOD24: begin
					em24_q  <= mod24_small(ev_ph_q);
					cp24_q  <= mod24_small(sphase_q);
					state_q <= ST_ARR;
				end
				ST_ARR: begin
					arr_q     <= arr_next;
					res_sh_q  <= RES_W'(arr_ph);
					res_q     <= '0;
					res_cnt_q <= RES_CNT_W'(RES_N - 1);
					state_q   <= ST_RES_ARR;
				end
				ST_RES_ARR: begin
					res_q    <= res_step;
					res_sh_q <= res_sh_q << DIG_W;
					if (res_cnt_q == '0) begin
						state_q <= ST_SYNC;
					end else begin
						res_cnt_q <= res_cnt_q - 1'b1;
					end
				end
				ST_SYNC: begin
					sync_q  <= sync_full[TIME_BITS-1:0];
					state_q <= ST_FIRST;
				end
				ST_FIRST: begin
					if (!pop_busy_q) begin
						last_q     <= first;
						push_cnt_q <= '0;
						state_q    <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (mem_we) begin
						tail_q  <= next_ptr(tail_q);
						count_q <= count_q + 1'b1;
					end else begin
						drop_q <= 1'b1;
					end
					if (push_cnt_q == RD_W'(READS_PER_TRIG - 1)) begin
						state_q <= ST_HEAD_RD;
					end else begin
						last_q     <= chained;
						push_cnt_q <= push_cnt_q + 1'b1;
					end
				end
				ST_HEAD_RD: begin
					state_q <= ST_HEAD_OUT;
				end
				ST_HEAD_OUT: begin
					if (out_free) begin
						out_ofs_q  <= ofs_sat;
						out_ph_q   <= rdata_q.phase;
						out_occ_q  <= OCC_W'(count_q);
						out_ovf_q  <= drop_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TRBS_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(BUF_DEPTH))
	`TRBS_ASSERT(a_ptr_meet, clk, arst_n, (count_q == '0 || count_q == CNT_W'(BUF_DEPTH)) |-> (tail_q == head_q))
	`TRBS_NEVER(a_write_during_pop, clk, arst_n, mem_we && pop_busy_q)
	`TRBS_ASSERT(a_ready_no_pop, clk, arst_n, s_tready |-> !pop_busy_q)
	`TRBS_ASSERT(a_result_nonempty, clk, arst_n, m_tvalid_q |-> (out_occ_q != '0))

endmodule

/* dv/trigger_readout_buffer_scheduler_tb.sv */
// Self-checking testbench for the trigger readout buffer scheduler: a scoreboard class predicts
// each readout result from the event stream and register writes, with random idling on both sides.
// Depends on trbs_pkg and the trigger_readout_buffer_scheduler top level only.
`timescale 1ns / 100ps

module trigger_readout_buffer_scheduler_tb;
	import trbs_pkg::*;

	localparam longint unsigned TIME_MASK = (64'd1 << TIME_BITS) - 64'd1;
	localparam longint OFS_MAX = 2 ** (OFFSET_W - 1) - 1;
	localparam longint OFS_MIN = -(2 ** (OFFSET_W - 1));
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 120;
	localparam int WATCHDOG_LIMIT = 4000;

	typedef struct packed {
		logic               ovf;
		logic [OCC_W-1:0]   occ;
		logic [PHASE_W-1:0] phase;
		logic [OFFSET_W-1:0] offset;
	} readout_t;

	class trigger_schedule_sb;
		logic [TIME_BITS-1:0] slot_time [BUF_DEPTH];
		logic [PHASE_W-1:0]   slot_phase [BUF_DEPTH];
		int unsigned          head_idx;
		int unsigned          tail_idx;
		int unsigned          fill;
		longint unsigned      last_read;
		longint unsigned      delay_ns;
		longint unsigned      sync_ph;
		readout_t             expected_q[$];
		int                   errors;

		function new();
			head_idx = 0;
			tail_idx = 0;
			fill = 0;
			last_read = 0;
			delay_ns = 0;
			sync_ph = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_TRIGGER_DELAY) begin
				delay_ns = value;
			end else begin
				sync_ph = value[PHASE_W-1:0];
			end
		endfunction

		function void note_event(logic [TIME_BITS-1:0] ev_in);
			longint unsigned ev;
			longint unsigned arrival;
			longint unsigned sync_t;
			longint unsigned read_t;
			longint          offset;
			bit              dropped;
			readout_t        want;
			ev = ev_in;
			arrival = ev + delay_ns + (CLK_NS - (ev + sync_ph % CLK_NS) % CLK_NS);
			arrival &= TIME_MASK;
			sync_t = (arrival + (SYNC_NS - (arrival + sync_ph) % SYNC_NS)) & TIME_MASK;
			while (fill > 0 && 64'(slot_time[head_idx]) + POP_AGE < ev) begin
				head_idx = (head_idx + 1) % BUF_DEPTH;
				fill--;
			end
			if (fill == 0) begin
				read_t = sync_t;
			end else begin
				read_t = (last_read + READ_SPACING) & TIME_MASK;
				if (sync_t > read_t) begin
					read_t = sync_t;
				end
			end
			dropped = 0;
			for (int k = 0; k < READS_PER_TRIG; k++) begin
				if (k > 0) begin
					read_t = (read_t + READ_SPACING) & TIME_MASK;
				end
				if (fill >= BUF_DEPTH) begin
					dropped = 1;
				end else begin
					slot_time[tail_idx] = read_t[TIME_BITS-1:0];
					slot_phase[tail_idx] = PHASE_W'(ev % SYNC_NS);
					tail_idx = (tail_idx + 1) % BUF_DEPTH;
					fill++;
				end
			end
			last_read = read_t;
			offset = longint'(64'(slot_time[head_idx])) - longint'(ev);
			if (offset > OFS_MAX) begin
				offset = OFS_MAX;
			end
			if (offset < OFS_MIN) begin
				offset = OFS_MIN;
			end
			want.offset = offset[OFFSET_W-1:0];
			want.phase = slot_phase[head_idx];
			want.occ = fill[OCC_W-1:0];
			want.ovf = dropped;
			expected_q.insert(expected_q.size(), want);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] word);
			readout_t got;
			readout_t want;
			got = word[OUT_FIELDS_W-1:0];
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, got %h", $time, word);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.offset !== want.offset) begin
				$display("%0t: head_offset expected %0d, got %0d", $time,
					$signed(want.offset), $signed(got.offset));
				errors++;
			end
			if (got.phase !== want.phase) begin
				$display("%0t: head_event_phase expected %0d, got %0d", $time,
					want.phase, got.phase);
				errors++;
			end
			if (got.occ !== want.occ) begin
				$display("%0t: occupancy expected %0d, got %0d", $time, want.occ, got.occ);
				errors++;
			end
			if (got.ovf !== want.ovf) begin
				$display("%0t: overflow expected %0d, got %0d", $time, want.ovf, got.ovf);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	// event_time
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	// head_offset, head_event_phase, occupancy, overflow, zero pad
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = REG_TRIGGER_DELAY;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	trigger_schedule_sb sb;
	bit                 steady = 0;
	bit                 hold_off_req = 0;
	int                 idle_cycles = 0;
	longint unsigned    stamp_ns = 0;

	trigger_readout_buffer_scheduler dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	function automatic int draw_gap();
		return steady ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic longint unsigned pick_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			return $urandom_range(0, 60);
		end else if (r < 60) begin
			return $urandom_range(61, 3400);
		end else if (r < 85) begin
			return $urandom_range(3401, 40000);
		end else if (r < 97) begin
			return $urandom_range(40001, 2000000);
		end
		return longint'($urandom);
	endfunction

	task automatic offer_event(input logic [TIME_BITS-1:0] t);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= IN_TDATA_W'(t);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			stamp_ns = (stamp_ns + pick_step()) & TIME_MASK;
			offer_event(stamp_ns[TIME_BITS-1:0]);
		end
		steady = 0;
	endtask

	task automatic drain_and_settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs(input logic [CFG_DATA_W-1:0] delay_word,
	                            input logic [CFG_DATA_W-1:0] phase_word);
		cfg_we <= 1'b1;
		cfg_index <= REG_TRIGGER_DELAY;
		cfg_data <= delay_word;
		@(posedge clk);
		sb.set_reg(REG_TRIGGER_DELAY, delay_word);
		cfg_index <= REG_SYNC_PHASE;
		cfg_data <= phase_word;
		@(posedge clk);
		sb.set_reg(REG_SYNC_PHASE, phase_word);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_event(s_tdata[TIME_BITS-1:0]);
			end
			if (m_tvalid && m_tready) begin
				sb.check_result(m_tdata);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("%0t: no transfer for %0d cycles", $time, idle_cycles);
					$display("status: fail");
					$finish;
				end
			end
		end
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (hold_off_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 0;
			end
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Early events, chaining at equal times, a full buffer, a full drain and
		// a partial drain, with zero delay and zero phase.
		program_regs('0, '0);
		offer_event(0);
		offer_event(0);
		offer_event(839);
		offer_event(840);
		repeat (9) offer_event(841);
		// Lands on a clock edge and then on a sync boundary: both move a full step.
		offer_event(2000016);
		offer_event(2010016);
		offer_event(2010016);
		stamp_ns = 2010016;
		drain_and_settle();

		program_regs(20'hFFFFF, 20'd839);
		hold_off_req = 1;
		steady = 1;
		repeat (24) begin
			stamp_ns = (stamp_ns + $urandom_range(0, 4000)) & TIME_MASK;
			offer_event(stamp_ns[TIME_BITS-1:0]);
		end
		steady = 0;
		run_random(146);
		drain_and_settle();

		program_regs(20'($urandom), {10'($urandom), 10'($urandom_range(0, 839))});
		run_random(170);
		drain_and_settle();

		program_regs(20'($urandom_range(0, 100)), {10'($urandom), 10'h3FF});
		run_random(170);
		drain_and_settle();

		program_regs(20'($urandom), 20'($urandom));
		run_random(170);
		drain_and_settle();

		// The timestamp counter runs through its top value and wraps.
		program_regs(20'($urandom), {10'($urandom), 10'($urandom_range(0, 839))});
		stamp_ns = TIME_MASK - 64'd4194303;
		run_random(30);
		offer_event(TIME_MASK[TIME_BITS-1:0]);
		stamp_ns = TIME_MASK;
		run_random(70);
		drain_and_settle();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
